// File: rtl/nnis_pkg.sv
`default_nettype none

package nnis_pkg;

    // fixed field widths
    localparam int COORD_W   = 16;
    localparam int FACTOR_W  = 24;
    localparam int FRAC_W    = 16;
    localparam int PIX_IO_W  = 32;
    localparam int SRC_DIM_W = 9;
    localparam int CFG_IDX_W = 2;

    // divider: dividend is the coordinate shifted up by the fraction width
    localparam int DVD_W     = COORD_W + FRAC_W;
    localparam int DIV_CNT_W = $clog2(DVD_W);

    // largest scaled size
    localparam logic [COORD_W-1:0] SIZE_MAX = 16'hFFFF;

    // request kinds
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR = 2'd2;

    // cycles for the scaled size to follow a register write
    localparam logic [1:0] CFG_SETTLE = 2'd2;

    // scaled image size
    typedef struct packed {
        logic [COORD_W-1:0] height;
        logic [COORD_W-1:0] width;
    } nnis_dims_t;

    // divider status toward the sequencer
    typedef struct packed {
        logic               done;
        logic [DVD_W-1:0]   quot_x;
        logic [DVD_W-1:0]   quot_y;
    } nnis_div_stat_t;

endpackage

`default_nettype wire

// File: rtl/nnis_frame_mem.sv
`default_nettype none

module nnis_frame_mem #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16,
    parameter int DATA_W = 32
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/nnis_size.sv
`default_nettype none

module nnis_size #(
    parameter int WW = 9,
    parameter int HW = 9
) (
    input  wire logic                             clk,
    input  wire logic [WW-1:0]                    width_eff,
    input  wire logic [HW-1:0]                    height_eff,
    input  wire logic [nnis_pkg::FACTOR_W-1:0]    factor,
    output nnis_pkg::nnis_dims_t                  dims
);

    import nnis_pkg::*;

    logic [WW+FACTOR_W-1:0] prod_w_reg;
    logic [HW+FACTOR_W-1:0] prod_h_reg;
    logic [31:0]            sh_w;
    logic [31:0]            sh_h;
    nnis_dims_t             dims_reg;
    nnis_dims_t             dims_next;

    // products of size and factor
    always_ff @(posedge clk)
    begin
        prod_w_reg <= (WW+FACTOR_W)'(width_eff) * (WW+FACTOR_W)'(factor);
        prod_h_reg <= (HW+FACTOR_W)'(height_eff) * (HW+FACTOR_W)'(factor);
    end

    // drop the fraction and saturate
    always_comb
    begin
        sh_w = 32'(prod_w_reg >> FRAC_W);
        sh_h = 32'(prod_h_reg >> FRAC_W);
        dims_next.width  = (sh_w > 32'(SIZE_MAX)) ? SIZE_MAX : sh_w[COORD_W-1:0];
        dims_next.height = (sh_h > 32'(SIZE_MAX)) ? SIZE_MAX : sh_h[COORD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        dims_reg <= dims_next;
    end

    assign dims = dims_reg;

endmodule

`default_nettype wire

// File: rtl/nnis_div.sv
`default_nettype none

module nnis_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [nnis_pkg::COORD_W-1:0]   coord_x,
    input  wire logic [nnis_pkg::COORD_W-1:0]   coord_y,
    input  wire logic [nnis_pkg::FACTOR_W-1:0]  divisor,
    output nnis_pkg::nnis_div_stat_t            stat
);

    import nnis_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [FACTOR_W-1:0]   dsr_reg;
    logic [FACTOR_W-1:0]   rem_x_reg;
    logic [FACTOR_W-1:0]   rem_y_reg;
    logic [DVD_W-1:0]      dvd_x_reg;
    logic [DVD_W-1:0]      dvd_y_reg;
    logic [FACTOR_W:0]     tx;
    logic [FACTOR_W:0]     ty;
    logic                  ge_x;
    logic                  ge_y;
    logic [FACTOR_W:0]     dx;
    logic [FACTOR_W:0]     dy;

    // one restoring step per lane
    always_comb
    begin
        tx   = {rem_x_reg, dvd_x_reg[DVD_W-1]};
        ty   = {rem_y_reg, dvd_y_reg[DVD_W-1]};
        ge_x = (tx >= {1'b0, dsr_reg});
        ge_y = (ty >= {1'b0, dsr_reg});
        dx   = tx - {1'b0, dsr_reg};
        dy   = ty - {1'b0, dsr_reg};
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DVD_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // remainders and quotient shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dsr_reg   <= divisor;
            rem_x_reg <= '0;
            rem_y_reg <= '0;
            dvd_x_reg <= {coord_x, {FRAC_W{1'b0}}};
            dvd_y_reg <= {coord_y, {FRAC_W{1'b0}}};
        end
        else if (busy_reg)
        begin
            rem_x_reg <= ge_x ? dx[FACTOR_W-1:0] : tx[FACTOR_W-1:0];
            rem_y_reg <= ge_y ? dy[FACTOR_W-1:0] : ty[FACTOR_W-1:0];
            dvd_x_reg <= {dvd_x_reg[DVD_W-2:0], ge_x};
            dvd_y_reg <= {dvd_y_reg[DVD_W-2:0], ge_y};
        end
    end

    assign stat.done   = done_reg;
    assign stat.quot_x = dvd_x_reg;
    assign stat.quot_y = dvd_y_reg;

endmodule

`default_nettype wire

// File: rtl/nearest_neighbor_image_scaler_unit.sv
// Nearest-neighbor scaler over a stored source frame.
// Input channel s_axis: tuser selects a pixel write (0) or a scaled read (1);
// tdata carries the coordinates and, for writes, the pixel word.
// Output channel m_axis: one item per write inside the source frame and per
// read; tuser is set on write items and flags a read inside the scaled image,
// tdata carries the pixel and the current scaled width and height. Writes
// outside the frame give no output item.
// cfg_we/cfg_index/cfg_data set source width, height and the Q8.16 factor;
// after a write s_axis_tready stays low while the scaled size is recomputed
// (one multiply stage, one saturation stage).
// A write shows its item in the cycle after it is taken; a read outside the
// image likewise. A read inside the image runs the bit-serial divider that
// maps both coordinates to source positions, one frame memory read, one
// output load. Items are taken one at a time: writes sustain one a cycle
// while the receiver is ready, an in-range read finishes before the next.
// Reset restores the default registers (256 x 256 source, factor 1.0); the
// frame contents are undefined until written. A stalled receiver holds the
// output register and no new item is taken until it drains.
`default_nettype none

module nearest_neighbor_image_scaler_unit #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int PIXEL_BITS = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration write port
    input  wire logic                            cfg_we,
    input  wire logic [nnis_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [nnis_pkg::FACTOR_W-1:0]   cfg_data,
    // request stream
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [63:0]                     s_axis_tdata,   // coord_x, coord_y, pixel_in
    input  wire logic                            s_axis_tuser,   // req_type
    // result stream
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic      [63:0]                     m_axis_tdata,   // pixel_out, out_width, out_height
    output logic                                 m_axis_tuser    // in_range
);

    import nnis_pkg::*;

    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    // frame address of a source position
    function automatic logic [AW-1:0] frame_addr(input logic [YW-1:0] yi,
                                                 input logic [XW-1:0] xi);
        logic [31:0] a;
        a = 32'(yi) * 32'(MAX_WIDTH) + 32'(xi);
        return a[AW-1:0];
    endfunction

    logic [SRC_DIM_W-1:0]   src_width_reg;
    logic [SRC_DIM_W-1:0]   src_height_reg;
    logic [FACTOR_W-1:0]    scale_factor_reg;
    logic [1:0]             settle_reg;
    logic [1:0]             state_reg;
    logic [1:0]             state_next;
    logic                   hit_reg;
    logic                   out_valid_reg;
    logic [63:0]            out_data_reg;
    logic                   out_user_reg;

    logic [WW-1:0]          width_eff;
    logic [HW-1:0]          height_eff;
    nnis_dims_t             dims;
    nnis_div_stat_t         div_stat;

    logic                   req_type;
    logic [COORD_W-1:0]     coord_x;
    logic [COORD_W-1:0]     coord_y;
    logic [PIX_IO_W-1:0]    pixel_in;

    logic                   accept;
    logic                   out_free;
    logic                   wr_inside;
    logic                   rd_inside;
    logic                   div_start;
    logic                   guard_ok;
    logic                   mem_we;
    logic                   mem_re;
    logic [AW-1:0]          mem_waddr;
    logic [AW-1:0]          mem_raddr;
    logic [PIXEL_BITS-1:0]  mem_rdata;
    logic                   load_out;
    logic [PIX_IO_W-1:0]    load_pixel;
    logic                   load_user;

    // unpack the request
    assign req_type = s_axis_tuser;
    assign coord_x  = s_axis_tdata[15:0];
    assign coord_y  = s_axis_tdata[31:16];
    assign pixel_in = s_axis_tdata[63:32];

    // configuration registers and settle count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg    <= SRC_DIM_W'(256);
            src_height_reg   <= SRC_DIM_W'(256);
            scale_factor_reg <= FACTOR_W'(65536);
            settle_reg       <= CFG_SETTLE;
        end
        else if (cfg_we)
        begin
            settle_reg <= CFG_SETTLE;
            unique case (cfg_index)
                CFG_SRC_WIDTH:    src_width_reg    <= cfg_data[SRC_DIM_W-1:0];
                CFG_SRC_HEIGHT:   src_height_reg   <= cfg_data[SRC_DIM_W-1:0];
                CFG_SCALE_FACTOR: scale_factor_reg <= cfg_data;
                default:          ;
            endcase
        end
        else if (settle_reg != '0)
        begin
            settle_reg <= settle_reg - 1'b1;
        end
    end

    // effective source size
    assign width_eff  = (16'(src_width_reg) > 16'(MAX_WIDTH)) ?
                        WW'(MAX_WIDTH) : WW'(src_width_reg);
    assign height_eff = (16'(src_height_reg) > 16'(MAX_HEIGHT)) ?
                        HW'(MAX_HEIGHT) : HW'(src_height_reg);

    nnis_size #(
        .WW (WW),
        .HW (HW)
    ) u_size (
        .clk        (clk),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .factor     (scale_factor_reg),
        .dims       (dims)
    );

    nnis_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .coord_x (coord_x),
        .coord_y (coord_y),
        .divisor (scale_factor_reg),
        .stat    (div_stat)
    );

    nnis_frame_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (AW),
        .DATA_W (PIXEL_BITS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (PIXEL_BITS'(pixel_in)),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // intake
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && (settle_reg == '0) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign wr_inside = (coord_x < 16'(width_eff)) && (coord_y < 16'(height_eff));
    assign rd_inside = (scale_factor_reg != '0) && (coord_x < dims.width)
                       && (coord_y < dims.height);

    assign mem_we    = accept && (req_type == REQ_WRITE) && wr_inside;
    assign mem_waddr = frame_addr(coord_y[YW-1:0], coord_x[XW-1:0]);
    assign div_start = accept && (req_type == REQ_READ) && rd_inside;

    // source position check and frame read once the divider finishes
    assign guard_ok  = (div_stat.quot_x < DVD_W'(width_eff))
                       && (div_stat.quot_y < DVD_W'(height_eff));
    assign mem_re    = (state_reg == S_DIV) && div_stat.done && guard_ok;
    assign mem_raddr = frame_addr(div_stat.quot_y[YW-1:0], div_stat.quot_x[XW-1:0]);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        load_out   = 1'b0;
        load_pixel = '0;
        load_user  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_WRITE)
                    begin
                        load_out  = wr_inside;
                        load_user = 1'b1;
                    end
                    else if (rd_inside)
                    begin
                        state_next = S_DIV;
                    end
                    else
                    begin
                        load_out = 1'b1;
                    end
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    load_user  = hit_reg;
                    load_pixel = hit_reg ? PIX_IO_W'(mem_rdata) : '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_DIV) && div_stat.done)
            begin
                hit_reg <= guard_ok;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= {dims.height, dims.width, load_pixel};
            out_user_reg <= load_user;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // divider finishes only while the sequencer waits for it
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIV))
        else $error("divider done outside of divide state");

    // frame memory never written and read in the same cycle
    a_mem_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("frame write and read overlap");

    // an item outside the scaled image carries a zero pixel
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[31:0] == '0))
        else $error("out-of-range item with nonzero pixel");

    // no item taken in the cycle after a register write
    a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !s_axis_tready)
        else $error("item taken before scaled size settled");

    // a read leaves the divide state only toward the output load
    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg) == S_DIV && state_reg != S_DIV) |-> (state_reg == S_OUT))
        else $error("divide state left without output load");

endmodule

`default_nettype wire
